// ----- hdl/sst_pkg.sv -----
// shared types and codes of the scoped symbol table
`default_nettype none

package sst_pkg;

  // command codes
  localparam logic [2:0] CMD_OPEN         = 3'd0;
  localparam logic [2:0] CMD_CLOSE        = 3'd1;
  localparam logic [2:0] CMD_DECLARE      = 3'd2;
  localparam logic [2:0] CMD_LOOKUP_ALL   = 3'd3;
  localparam logic [2:0] CMD_LOOKUP_INNER = 3'd4;

  // status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_DUPLICATE = 3'd1;
  localparam logic [2:0] STS_NOT_FOUND = 3'd2;
  localparam logic [2:0] STS_NO_SCOPE  = 3'd3;
  localparam logic [2:0] STS_FULL      = 3'd4;
  localparam logic [2:0] STS_DEPTH     = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] symbol_id;
    logic [31:0] symbol_payload;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_payload;
    logic [4:0]  found_level;
    logic [4:0]  scope_depth;
  } rsp_t;

  // flags carried by the search token along the cell row
  typedef struct packed {
    logic found;
    logic cut_hit;
  } tok_flags_t;

endpackage

`default_nettype wire

// ----- hdl/sst_cell.sv -----
// one entry cell: stores an id, payload and scope level, and updates the passing search token
`default_nettype none

module sst_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7,
  parameter int LVL_W = 5,
  parameter int PW    = 32
) (
  input  wire logic                    clk_i,
  // broadcast from the controller
  input  wire logic [31:0]             key_i,
  input  wire logic [LVL_W-1:0]        top_i,
  input  wire logic                    all_i,
  input  wire logic [CNT_W-1:0]        count_i,
  // entry write
  input  wire logic                    wr_en_i,
  input  wire logic [CNT_W-1:0]        wr_idx_i,
  input  wire logic [31:0]             wr_id_i,
  input  wire logic [PW-1:0]           wr_pay_i,
  input  wire logic [LVL_W-1:0]        wr_lvl_i,
  // token from the upper neighbour
  input  wire sst_pkg::tok_flags_t     flags_i,
  input  wire logic [PW-1:0]           pay_i,
  input  wire logic [LVL_W-1:0]        lvl_i,
  input  wire logic [CNT_W-1:0]        cut_i,
  // token to the lower neighbour
  output sst_pkg::tok_flags_t          flags_o,
  output logic [PW-1:0]                pay_o,
  output logic [LVL_W-1:0]             lvl_o,
  output logic [CNT_W-1:0]             cut_o
);

  logic [31:0]         id_q;
  logic [PW-1:0]       epay_q;
  logic [LVL_W-1:0]    elvl_q;

  sst_pkg::tok_flags_t flags_d, flags_q;
  logic [PW-1:0]       pay_d, pay_q;
  logic [LVL_W-1:0]    lvl_d, lvl_q;
  logic [CNT_W-1:0]    cut_d, cut_q;

  logic live, in_top, hit, take;

  assign live   = CNT_W'(INDEX) < count_i;
  assign in_top = live && (elvl_q == top_i);
  assign hit    = live && (id_q == key_i) && (all_i || (elvl_q == top_i));
  // the first hit seen on the way down is the innermost one
  assign take   = hit && !flags_i.found;

  always_comb begin
    flags_d.found   = flags_i.found | hit;
    flags_d.cut_hit = flags_i.cut_hit | in_top;
    pay_d           = take ? epay_q : pay_i;
    lvl_d           = take ? elvl_q : lvl_i;
    // lowest cell of the top scope wins, as it is visited last
    cut_d           = in_top ? CNT_W'(INDEX) : cut_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == CNT_W'(INDEX))) begin
      id_q   <= wr_id_i;
      epay_q <= wr_pay_i;
      elvl_q <= wr_lvl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
    pay_q   <= pay_d;
    lvl_q   <= lvl_d;
    cut_q   <= cut_d;
  end

  assign flags_o = flags_q;
  assign pay_o   = pay_q;
  assign lvl_o   = lvl_q;
  assign cut_o   = cut_q;

endmodule

`default_nettype wire

// ----- hdl/sst_ctrl.sv -----
// command sequencer: holds scope depth and entry count, runs the scan and forms each result
`default_nettype none

module sst_ctrl #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_SCOPES  = 16,
  parameter int CNT_W       = 7,
  parameter int LVL_W       = 5,
  parameter int PW          = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire sst_pkg::req_t        req_i,
  output logic                      busy_o,
  output logic                      done_o,
  output sst_pkg::rsp_t             rsp_o,
  // broadcast to the cells
  output logic [31:0]               key_o,
  output logic [LVL_W-1:0]          top_o,
  output logic                      all_o,
  output logic [CNT_W-1:0]          count_o,
  // entry write
  output logic                      wr_en_o,
  output logic [CNT_W-1:0]          wr_idx_o,
  output logic [31:0]               wr_id_o,
  output logic [PW-1:0]             wr_pay_o,
  output logic [LVL_W-1:0]          wr_lvl_o,
  // token leaving the bottom cell
  input  wire sst_pkg::tok_flags_t  flags_i,
  input  wire logic [PW-1:0]        pay_i,
  input  wire logic [LVL_W-1:0]     lvl_i,
  input  wire logic [CNT_W-1:0]     cut_i
);

  localparam int SCAN_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  sst_pkg::state_e  state_d, state_q;
  logic [SCAN_W-1:0] cnt_d, cnt_q;
  logic [2:0]        cmd_q;
  logic [31:0]       key_q;
  logic [PW-1:0]     pay_q;
  logic [CNT_W-1:0]  count_d, count_q;
  logic [LVL_W-1:0]  depth_d, depth_q;
  logic [LVL_W-1:0]  eff_depth;
  logic              accept, fin, wr_en;
  logic              done_q;
  sst_pkg::rsp_t     rsp_d, rsp_q;
  logic              needs_scan;

  assign accept = start_i && (state_q == sst_pkg::ST_IDLE);
  assign fin    = (state_q == sst_pkg::ST_FIN);

  always_comb begin
    case (req_i.command)
      sst_pkg::CMD_CLOSE,
      sst_pkg::CMD_DECLARE,
      sst_pkg::CMD_LOOKUP_ALL,
      sst_pkg::CMD_LOOKUP_INNER: needs_scan = 1'b1;
      default:                   needs_scan = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      sst_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          state_d = needs_scan ? sst_pkg::ST_SCAN : sst_pkg::ST_FIN;
        end
      end
      sst_pkg::ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SCAN_W'(MAX_ENTRIES - 1)) begin
          state_d = sst_pkg::ST_FIN;
        end
      end
      sst_pkg::ST_FIN: begin
        state_d = sst_pkg::ST_IDLE;
      end
      default: begin
        state_d = sst_pkg::ST_IDLE;
      end
    endcase
  end

  // a declare with no open scope opens the outermost one first
  assign eff_depth = ((cmd_q == sst_pkg::CMD_DECLARE) && (depth_q == '0)) ?
                     LVL_W'(1) : depth_q;

  // outputs of the finishing step
  always_comb begin
    rsp_d   = '0;
    count_d = count_q;
    depth_d = depth_q;
    wr_en   = 1'b0;
    case (cmd_q)
      sst_pkg::CMD_OPEN: begin
        if (depth_q >= LVL_W'(MAX_SCOPES)) begin
          rsp_d.status = sst_pkg::STS_DEPTH;
        end else begin
          depth_d = depth_q + 1'b1;
        end
      end
      sst_pkg::CMD_CLOSE: begin
        if (depth_q == '0) begin
          rsp_d.status = sst_pkg::STS_NO_SCOPE;
        end else begin
          depth_d = depth_q - 1'b1;
          if (flags_i.cut_hit) begin
            count_d = cut_i;
          end
        end
      end
      sst_pkg::CMD_DECLARE: begin
        depth_d = eff_depth;
        if (flags_i.found) begin
          rsp_d.status        = sst_pkg::STS_DUPLICATE;
          rsp_d.found_payload = 32'(pay_i);
          rsp_d.found_level   = 5'(eff_depth);
        end else if (count_q >= CNT_W'(MAX_ENTRIES)) begin
          rsp_d.status = sst_pkg::STS_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      sst_pkg::CMD_LOOKUP_ALL: begin
        if ((depth_q != '0) && flags_i.found) begin
          rsp_d.found_payload = 32'(pay_i);
          rsp_d.found_level   = 5'(lvl_i);
        end else begin
          rsp_d.status = sst_pkg::STS_NOT_FOUND;
        end
      end
      sst_pkg::CMD_LOOKUP_INNER: begin
        if ((depth_q != '0) && flags_i.found) begin
          rsp_d.found_payload = 32'(pay_i);
          rsp_d.found_level   = 5'(depth_q);
        end else begin
          rsp_d.status = sst_pkg::STS_NOT_FOUND;
        end
      end
      default: begin
        rsp_d.status = sst_pkg::STS_OK;
      end
    endcase
    rsp_d.scope_depth = 5'(depth_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sst_pkg::ST_IDLE;
      cnt_q   <= '0;
      count_q <= '0;
      depth_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= fin;
      if (fin) begin
        count_q <= count_d;
        depth_q <= depth_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.command;
      key_q <= req_i.symbol_id;
      pay_q <= req_i.symbol_payload[PW-1:0];
    end
    if (fin) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o   = (state_q != sst_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign rsp_o    = rsp_q;

  assign key_o    = key_q;
  assign top_o    = eff_depth;
  assign all_o    = (cmd_q == sst_pkg::CMD_LOOKUP_ALL);
  assign count_o  = count_q;

  assign wr_en_o  = fin && wr_en;
  assign wr_idx_o = count_q;
  assign wr_id_o  = key_q;
  assign wr_pay_o = pay_q;
  assign wr_lvl_o = eff_depth;

endmodule

`default_nettype wire

// ----- hdl/scoped_symbol_table.sv -----
// top level of the scoped symbol table: sequencer and a row of entry cells
//
//  channel  | ports                  | handshake
//  ---------+------------------------+----------------------------------------
//  request  | start_i, req_i, busy_o | taken at a clock edge with start_i high
//           |                        | and busy_o low
//  result   | done_o, rsp_o          | one-cycle strobe, always taken
//
// open and commands 5 to 7 skip the scan and go straight to the finishing step;
// close, declare and both lookups scan first, with the search token walking the
// cell row one cell a cycle from the newest entry to the oldest.
// busy_o stays high from the request until its result strobe.
// reset clears the entry count and the scope depth; cell contents are undefined
// until written and are never read before then.
`default_nettype none

module scoped_symbol_table #(
  parameter int MAX_ENTRIES   = 64,
  parameter int MAX_SCOPES    = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire sst_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output sst_pkg::rsp_t      rsp_o
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int LVL_W = $clog2(MAX_SCOPES + 1);
  localparam int PW    = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;

  logic [31:0]      key;
  logic [LVL_W-1:0] top;
  logic             all_scopes;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic [CNT_W-1:0] wr_idx;
  logic [31:0]      wr_id;
  logic [PW-1:0]    wr_pay;
  logic [LVL_W-1:0] wr_lvl;

  // token chain: element MAX_ENTRIES enters the top cell, element 0 leaves the bottom
  sst_pkg::tok_flags_t chain_flags [MAX_ENTRIES+1];
  logic [PW-1:0]       chain_pay   [MAX_ENTRIES+1];
  logic [LVL_W-1:0]    chain_lvl   [MAX_ENTRIES+1];
  logic [CNT_W-1:0]    chain_cut   [MAX_ENTRIES+1];

  assign chain_flags[MAX_ENTRIES] = '0;
  assign chain_pay[MAX_ENTRIES]   = '0;
  assign chain_lvl[MAX_ENTRIES]   = '0;
  assign chain_cut[MAX_ENTRIES]   = '0;

  sst_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_SCOPES  (MAX_SCOPES),
    .CNT_W       (CNT_W),
    .LVL_W       (LVL_W),
    .PW          (PW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .req_i    (req_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .rsp_o    (rsp_o),
    .key_o    (key),
    .top_o    (top),
    .all_o    (all_scopes),
    .count_o  (count),
    .wr_en_o  (wr_en),
    .wr_idx_o (wr_idx),
    .wr_id_o  (wr_id),
    .wr_pay_o (wr_pay),
    .wr_lvl_o (wr_lvl),
    .flags_i  (chain_flags[0]),
    .pay_i    (chain_pay[0]),
    .lvl_i    (chain_lvl[0]),
    .cut_i    (chain_cut[0])
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    sst_cell #(
      .INDEX (i),
      .CNT_W (CNT_W),
      .LVL_W (LVL_W),
      .PW    (PW)
    ) u_cell (
      .clk_i    (clk_i),
      .key_i    (key),
      .top_i    (top),
      .all_i    (all_scopes),
      .count_i  (count),
      .wr_en_i  (wr_en),
      .wr_idx_i (wr_idx),
      .wr_id_i  (wr_id),
      .wr_pay_i (wr_pay),
      .wr_lvl_i (wr_lvl),
      .flags_i  (chain_flags[i+1]),
      .pay_i    (chain_pay[i+1]),
      .lvl_i    (chain_lvl[i+1]),
      .cut_i    (chain_cut[i+1]),
      .flags_o  (chain_flags[i]),
      .pay_o    (chain_pay[i]),
      .lvl_o    (chain_lvl[i]),
      .cut_o    (chain_cut[i])
    );
  end

endmodule

`default_nettype wire
